// ----- rtl/core/assert_macros.svh -----
// assertion helpers for the scanner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// ----- rtl/core/cssts_pkg.sv -----
package cssts_pkg;

    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int LEN_OUT_W        = 16;
    localparam logic [LEN_OUT_W-1:0] LEN_MAX = 16'hFFFF;

    // result status codes
    localparam logic [1:0] ST_MATCH    = 2'd0;
    localparam logic [1:0] ST_NOMATCH  = 2'd1;
    localparam logic [1:0] ST_BADUTF   = 2'd2;
    localparam logic [1:0] ST_NOTQUOTE = 2'd3;

    // scan phase codes
    localparam logic [2:0] PH_QUOTE = 3'd0;
    localparam logic [2:0] PH_SCAN  = 3'd1;
    localparam logic [2:0] PH_ESC   = 3'd2;
    localparam logic [2:0] PH_CONT  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
    } t_item;

    typedef struct packed {
        logic                 emit;
        logic [1:0]           status;
        logic [LEN_OUT_W-1:0] token_length;
    } t_scan_res;

    typedef struct packed {
        logic       ok;
        logic [1:0] extra;
    } t_lead;

    // number of continuation bytes after a non-ascii lead byte, and whether the lead is valid
    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead r;
        r.ok    = 1'b1;
        r.extra = 2'd0;
        if ((b & 8'hE0) == 8'hC0) begin
            r.extra = 2'd1;
        end else if ((b & 8'hF0) == 8'hE0) begin
            r.extra = 2'd2;
        end else if ((b & 8'hF8) == 8'hF0) begin
            r.extra = 2'd3;
        end else if ((b & 8'h80) != 8'h00) begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_newline(input logic [7:0] b);
        return (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

// ----- rtl/core/cssts_in_stage.sv -----
module cssts_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,  // data_byte
    input  logic              s_axis_tlast,  // line_end
    input  logic              i_take,
    output logic              o_valid,
    output cssts_pkg::t_item  o_item
);
    import cssts_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign s_axis_tready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.data_byte <= s_axis_tdata;
            r_item.line_end  <= s_axis_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/core/cssts_scan.sv -----
`include "assert_macros.svh"

module cssts_scan #(
    parameter int LENGTH_WIDTH = cssts_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  cssts_pkg::t_item     i_item,
    output cssts_pkg::t_scan_res o_res
);
    import cssts_pkg::*;

    localparam int LW_EXT = (LENGTH_WIDTH > LEN_OUT_W) ? LENGTH_WIDTH : LEN_OUT_W;

    logic [2:0]              r_phase, n_phase;
    logic [7:0]              r_quote, n_quote;
    logic [LENGTH_WIDTH-1:0] r_count, n_count;
    logic [1:0]              r_cont, n_cont;

    logic [LENGTH_WIDTH-1:0] count_inc;
    logic [LW_EXT-1:0]       count_ext;
    logic [1:0]              cont_dec;
    logic                    hit;
    logic                    emit;
    logic [1:0]              st;
    t_lead                   lead;
    logic [7:0]              b;

    assign b         = i_item.data_byte;
    assign lead      = lead_decode(b);
    assign count_inc = (&r_count) ? r_count : r_count + LENGTH_WIDTH'(1);
    assign cont_dec  = (r_cont != 2'd0) ? r_cont - 2'd1 : 2'd0;

    always_comb begin
        n_phase = r_phase;
        n_quote = r_quote;
        n_count = r_count;
        n_cont  = r_cont;
        hit     = 1'b0;
        st      = ST_MATCH;

        unique case (r_phase)
            PH_QUOTE: begin
                if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                    n_quote = b;
                    n_count = LENGTH_WIDTH'(1);
                    n_phase = PH_SCAN;
                end else begin
                    hit = 1'b1;
                    st  = ST_NOTQUOTE;
                end
            end
            PH_SCAN, PH_ESC: begin
                n_count = count_inc;
                if (!b[7]) begin
                    if (r_phase == PH_SCAN && b == r_quote) begin
                        hit = 1'b1;
                        st  = ST_MATCH;
                    end else if (r_phase == PH_SCAN && b == CH_BSL) begin
                        n_phase = PH_ESC;
                    end else if (is_newline(b)) begin
                        hit = 1'b1;
                        st  = ST_NOMATCH;
                    end else begin
                        n_phase = PH_SCAN;
                    end
                end else if (!lead.ok) begin
                    hit = 1'b1;
                    st  = ST_BADUTF;
                end else begin
                    n_cont  = lead.extra;
                    n_phase = PH_CONT;
                end
            end
            PH_CONT: begin
                n_count = count_inc;
                n_cont  = cont_dec;
                if (cont_dec == 2'd0) begin
                    n_phase = PH_SCAN;
                end
            end
            default: begin
            end
        endcase

        emit = 1'b0;
        if (n_phase == PH_DONE) begin
            emit = 1'b0;
        end else if (hit) begin
            emit    = 1'b1;
            n_phase = PH_DONE;
        end else if (i_item.line_end) begin
            emit = 1'b1;
            st   = ST_NOMATCH;
        end

        if (i_item.line_end) begin
            n_phase = PH_QUOTE;
            n_cont  = 2'd0;
        end
    end

    // saturate the length at the output width
    assign count_ext = LW_EXT'(n_count);
    assign o_res.emit   = emit;
    assign o_res.status = st;
    assign o_res.token_length = (st != ST_MATCH) ? '0 :
                                (count_ext > LW_EXT'(LEN_MAX)) ? LEN_MAX :
                                count_ext[LEN_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_QUOTE;
            r_quote <= '0;
            r_count <= '0;
            r_cont  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_quote <= n_quote;
            r_count <= n_count;
            r_cont  <= n_cont;
        end
    end

    `ASSERT_NEVER(a_done_silent, i_clk, i_rst_n, r_phase == PH_DONE && !i_item.line_end && o_res.emit, "decided line reported again")
    `ASSERT_PROP(a_notquote_phase, i_clk, i_rst_n, (o_res.emit && o_res.status == ST_NOTQUOTE) |-> (r_phase == PH_QUOTE), "not-quote status outside opening phase")
    `ASSERT_PROP(a_line_end_reset, i_clk, i_rst_n, (i_fire && i_item.line_end) |=> (r_phase == PH_QUOTE && r_cont == 2'd0), "line end did not rearm scanner")

endmodule

// ----- rtl/core/css_string_token_scanner.sv -----
// css string token scanner
// input channel (s_axis): one byte of a line per item in tdata, tlast marks the
// last byte of the line. the first byte of each line must be the opening quote.
// output channel (m_axis): at most one item per line. tuser carries the status
// (0 matched, 1 no match, 2 bad utf-8 lead byte, 3 first byte not a quote),
// tdata the token length including both quotes, zero unless matched.
// an input item is registered on acceptance and decided in the following
// cycle; its result is then registered in the output register and offered from there.
// throughput is one byte per cycle, except where a pending result stalls the input as below.
// the output register lets the next byte be taken while a result waits; when
// m_axis_tready is low and a result is pending, a byte that would give another
// result waits in the input register and s_axis_tready drops.
// synchronous active-low reset empties both registers and rearms the scanner
// to expect an opening quote.
`include "assert_macros.svh"

module css_string_token_scanner #(
    parameter int LENGTH_WIDTH = cssts_pkg::LENGTH_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // token_length
    output logic [1:0]  m_axis_tuser    // status
);
    import cssts_pkg::*;

    logic      in_valid;
    t_item     in_item;
    t_scan_res res;
    logic      advance;
    logic      load;

    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [LEN_OUT_W-1:0] r_out_len;

    assign advance = in_valid && (!res.emit || !r_out_valid || m_axis_tready);
    assign load    = advance && res.emit;

    cssts_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_take        (advance),
        .o_valid       (in_valid),
        .o_item        (in_item)
    );

    cssts_scan #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (in_item),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_status <= res.status;
            r_out_len    <= res.token_length;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_len;
    assign m_axis_tuser  = r_out_status;

    `ASSERT_PROP(a_len_zero, i_clk, i_rst_n, (r_out_valid && r_out_status != ST_MATCH) |-> (r_out_len == '0), "length set without a match")
    `ASSERT_PROP(a_match_len, i_clk, i_rst_n, (r_out_valid && r_out_status == ST_MATCH) |-> (r_out_len >= LEN_OUT_W'(2)), "match shorter than two quotes")
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, load && r_out_valid && !m_axis_tready, "pending result overwritten")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import cssts_pkg::*;

    localparam int LONG_IDLE_MAX = 40;

    typedef struct {
        logic [7:0] b;
        logic       last;
    } t_line_byte;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] len;
    } t_token_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // data_byte
    logic        s_axis_tlast = 1'b0;    // line_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // token_length
    logic [1:0]  m_axis_tuser;           // status

    css_string_token_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_line_byte line_q[$];
    logic [7:0] line_buf[$];
    t_token_res expected_tokens[$];

    int     err_count = 0;
    int     lines_built = 0;
    int     bytes_sent = 0;
    int     results_seen = 0;
    int     status_tally[4] = '{0, 0, 0, 0};
    longint cycle_count = 0;
    longint cycle_limit = 0;

    // scanner state mirrored by the predictor
    logic [2:0]  scan_ph = PH_QUOTE;
    logic [7:0]  open_q = 8'h00;
    logic [15:0] tok_count = 16'd0;
    logic [1:0]  cont_left = 2'd0;

    function automatic int utf8_tail(input logic [7:0] b);
        casez (b)
            8'b0???????: return 0;
            8'b110?????: return 1;
            8'b1110????: return 2;
            8'b11110???: return 3;
            default:     return -1;
        endcase
    endfunction

    function automatic logic is_eol(input logic [7:0] b);
        return (b == CH_LF) || (b == CH_CR);
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic [1:0] st;
        logic       decided;
        int         tail;
        t_token_res r;
        st = ST_NOMATCH;
        decided = 1'b0;
        tail = 0;
        case (scan_ph)
            PH_QUOTE: begin
                if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                    open_q = b;
                    tok_count = 16'd1;
                    scan_ph = PH_SCAN;
                end else begin
                    st = ST_NOTQUOTE;
                    decided = 1'b1;
                end
            end
            PH_SCAN, PH_ESC: begin
                if (tok_count != 16'hFFFF) tok_count++;
                if (!b[7]) begin
                    if (scan_ph == PH_SCAN && b == open_q) begin
                        st = ST_MATCH;
                        decided = 1'b1;
                    end else if (is_eol(b)) begin
                        st = ST_NOMATCH;
                        decided = 1'b1;
                    end else if (scan_ph == PH_SCAN && b == CH_BSL) begin
                        scan_ph = PH_ESC;
                    end else begin
                        scan_ph = PH_SCAN;
                    end
                end else begin
                    tail = utf8_tail(b);
                    if (tail < 0) begin
                        st = ST_BADUTF;
                        decided = 1'b1;
                    end else begin
                        cont_left = 2'(tail);
                        scan_ph = PH_CONT;
                    end
                end
            end
            PH_CONT: begin
                if (tok_count != 16'hFFFF) tok_count++;
                if (cont_left > 0) cont_left--;
                if (cont_left == 0) scan_ph = PH_SCAN;
            end
            default: ;
        endcase

        if (scan_ph != PH_DONE && (decided || last)) begin
            r.status = decided ? st : ST_NOMATCH;
            r.len = (decided && st == ST_MATCH) ? tok_count : 16'd0;
            expected_tokens = {expected_tokens, r};
            if (decided) scan_ph = PH_DONE;
        end
        if (last) begin
            scan_ph = PH_QUOTE;
            cont_left = 2'd0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        err_count++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, LONG_IDLE_MAX);
    endfunction

    task automatic put(input logic [7:0] b);
        line_buf = {line_buf, b};
    endtask

    task automatic push_line();
        t_line_byte e;
        for (int i = 0; i < line_buf.size(); i++) begin
            e.b = line_buf[i];
            e.last = (i == line_buf.size() - 1);
            line_q = {line_q, e};
        end
        line_buf.delete();
        lines_built++;
    endtask

    function automatic logic [7:0] plain_char(input logic [7:0] q);
        logic [7:0] c;
        c = 8'($urandom_range(0, 127));
        while (c == q || c == CH_BSL || is_eol(c)) c = 8'($urandom_range(0, 127));
        return c;
    endfunction

    function automatic logic [7:0] lead_byte(input int k);
        case (k)
            1:       return 8'hC0 | 8'($urandom_range(0, 31));
            2:       return 8'hE0 | 8'($urandom_range(0, 15));
            default: return 8'hF0 | 8'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [7:0] bad_lead();
        if ($urandom_range(0, 1)) return 8'($urandom_range(8'h80, 8'hBF));
        return 8'($urandom_range(8'hF8, 8'hFF));
    endfunction

    task automatic put_utf8(input logic any_tail);
        int k;
        k = $urandom_range(1, 3);
        put(lead_byte(k));
        repeat (k) put(any_tail ? 8'($urandom) : (8'h80 | 8'($urandom_range(0, 63))));
    endtask

    task automatic put_chunk(input logic [7:0] q);
        int r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            put(plain_char(q));
        end else if (r < 58) begin
            put(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
        end else if (r < 68) begin
            c = 8'($urandom_range(0, 127));
            while (is_eol(c)) c = 8'($urandom_range(0, 127));
            put(CH_BSL);
            put(c);
        end else if (r < 75) begin
            put(CH_BSL);
            put_utf8(1'b0);
        end else begin
            put_utf8(r >= 95);
        end
    endtask

    task automatic random_line();
        int kind;
        int n;
        int ending;
        int k;
        logic [7:0] q;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 8)) put(8'($urandom));
            push_line();
            return;
        end
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        if (kind < 10) begin
            c = 8'($urandom);
            while (c == CH_DQUOTE || c == CH_SQUOTE) c = 8'($urandom);
            put(c);
        end else begin
            put(q);
        end
        n = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 12) : $urandom_range(13, 60);
        repeat (n) put_chunk(q);
        ending = $urandom_range(0, 99);
        if (ending < 70) begin
            put(q);
            if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 3)) put(8'($urandom));
        end else if (ending < 78) begin
            ;
        end else if (ending < 83) begin
            put($urandom_range(0, 1) ? CH_LF : CH_CR);
        end else if (ending < 88) begin
            put(CH_BSL);
            put($urandom_range(0, 1) ? CH_LF : CH_CR);
        end else if (ending < 92) begin
            put(CH_BSL);
        end else if (ending < 96) begin
            if ($urandom_range(0, 1)) put(CH_BSL);
            put(bad_lead());
        end else begin
            k = $urandom_range(1, 3);
            put(lead_byte(k));
            repeat ($urandom_range(0, k - 1)) put(8'h80 | 8'($urandom_range(0, 63)));
        end
        push_line();
    endtask

    // source side
    int   src_gap = 0;
    logic src_calm = 1'b0;
    logic src_holding;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            src_holding = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                scan_byte(s_axis_tdata, s_axis_tlast);
                line_q.delete(0);
                bytes_sent++;
                src_holding = 1'b0;
                src_gap = src_calm ? 0 : idle_len();
                if ($urandom_range(0, 199) == 0) src_calm = !src_calm;
            end
            if (!src_holding) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (line_q.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= line_q[0].b;
                    s_axis_tlast <= line_q[0].last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    int         sink_stall = 0;
    logic       sink_calm = 1'b0;
    t_token_res want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                status_tally[m_axis_tuser]++;
                if (expected_tokens.size() == 0) begin
                    report_mismatch($sformatf("unexpected item: status %0d length %0d",
                                              m_axis_tuser, m_axis_tdata));
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch($sformatf("result %0d: status %0d, want %0d",
                                                  results_seen, m_axis_tuser, want.status));
                    if (m_axis_tdata !== want.len)
                        report_mismatch($sformatf("result %0d: length %0d, want %0d",
                                                  results_seen, m_axis_tdata, want.len));
                end
            end
            if (sink_stall == 0 && !sink_calm && $urandom_range(0, 3) == 0)
                sink_stall = idle_len();
            if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
            if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_limit > 0 && cycle_count > cycle_limit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_tokens.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // non-quote first byte, rest of line ignored
        put(8'h78); put(CH_DQUOTE); put(CH_DQUOTE); push_line();
        // line ends right after the opening quote
        put(CH_SQUOTE); push_line();
        // line ends after a backslash
        put(CH_DQUOTE); put(CH_BSL); push_line();
        // bare newline, then ignored bytes
        put(CH_DQUOTE); put(CH_LF); put(CH_DQUOTE); push_line();
        // escaped carriage return
        put(CH_SQUOTE); put(CH_BSL); put(CH_CR); push_line();
        // escaped quote and a zero byte before the match
        put(CH_DQUOTE); put(CH_BSL); put(CH_DQUOTE); put(8'h00); put(CH_DQUOTE); push_line();
        // quote and newline hidden inside a four-byte sequence
        put(CH_SQUOTE); put(8'hF0); put(CH_SQUOTE); put(CH_LF); put(CH_DQUOTE);
        put(CH_SQUOTE); push_line();
        // stray continuation byte in lead position
        put(CH_DQUOTE); put(8'h80); push_line();
        // bad lead byte after a backslash
        put(CH_SQUOTE); put(CH_BSL); put(8'hFF); put(CH_SQUOTE); push_line();
        // line ends inside a sequence
        put(CH_DQUOTE); put(8'hE2); put(8'h82); push_line();
        // escaped two-byte sequence, other quote kind inside
        put(CH_SQUOTE); put(CH_BSL); put(8'hC3); put(8'hA9); put(CH_DQUOTE);
        put(CH_SQUOTE); push_line();

        while (line_q.size() < 1010) random_line();

        cycle_limit = 4 * (longint'(line_q.size()) * (LONG_IDLE_MAX + 2)
                      + longint'(lines_built) * (LONG_IDLE_MAX + 4)) + 1000;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (line_q.size() > 0 || expected_tokens.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("scanned %0d bytes in %0d lines with random gaps and stalls",
                 bytes_sent, lines_built);
        $display("checked %0d results: %0d matched, %0d no match, %0d bad lead, %0d not quote",
                 results_seen, status_tally[ST_MATCH], status_tally[ST_NOMATCH],
                 status_tally[ST_BADUTF], status_tally[ST_NOTQUOTE]);
        if (err_count == 0 && expected_tokens.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- css_string_token_scanner.f -----
+incdir+rtl/core
rtl/core/cssts_pkg.sv
rtl/core/cssts_in_stage.sv
rtl/core/cssts_scan.sv
rtl/core/css_string_token_scanner.sv
verif/tb_top.sv
